FILE: hdl/vsc_pkg.sv
// Shared types and constants for the Vigenere stream cipher core.
// Holds character codes, register indexes and the structs passed between the front,
// the queue and the back. Depends on nothing.
package vsc_pkg;

	// Character codes and alphabet size.
	localparam logic [7:0] CHAR_UP_A = 8'h41;
	localparam logic [7:0] CHAR_UP_Z = 8'h5A;
	localparam logic [7:0] CHAR_LO_A = 8'h61;
	localparam logic [7:0] CHAR_LO_Z = 8'h7A;
	localparam logic [4:0] ALPHABET  = 5'd26;

	// Field and register widths.
	localparam int BYTE_W      = 8;
	localparam int SHIFT_W     = 5;
	localparam int KEY_LEN_W   = 6;
	localparam int KEY_REG_W   = 60;
	localparam int KEY_REGS    = 4;
	localparam int KEY_BITS    = KEY_REG_W * KEY_REGS;
	localparam int REG_INDEX_W = 3;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// Configuration register indexes.
	typedef enum logic [REG_INDEX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_KEY_LENGTH   = 3'd1,
		REG_KEY_SHIFTS_0 = 3'd2,
		REG_KEY_SHIFTS_1 = 3'd3,
		REG_KEY_SHIFTS_2 = 3'd4,
		REG_KEY_SHIFTS_3 = 3'd5
	} cfg_reg_t;

	// One classified character waiting for the back end.
	typedef struct packed {
		logic [BYTE_W-1:0]  text_byte;
		logic               is_letter;
		logic               is_lower;
		logic [SHIFT_W-1:0] offset;
		logic [SHIFT_W-1:0] shift;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic [KEY_LEN_W-1:0] key_position;
	} front_status_t;

endpackage

FILE: hdl/vsc_stream_if.sv
// Valid/ready stream interfaces for the text and result channels of the cipher core.
// Depends on vsc_pkg for field widths.
interface vsc_text_if;
	logic                         valid;
	logic                         ready;
	logic [vsc_pkg::BYTE_W-1:0]   text_byte;
	logic                         start_of_message;

	modport source (output valid, output text_byte, output start_of_message, input ready);
	modport sink   (input valid, input text_byte, input start_of_message, output ready);
endinterface

interface vsc_result_if;
	logic                         valid;
	logic                         ready;
	logic [vsc_pkg::BYTE_W-1:0]   result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink   (input valid, input result_byte, output ready);
endinterface

FILE: hdl/vigenere_stream_cipher_core.sv
// Top level of the Vigenere stream cipher core with its configuration registers.
// Depends on vsc_pkg, vsc_stream_if, vsc_front, vsc_queue and vsc_back.
//
// The core takes one text byte per transaction on text_ch and returns one byte per
// transaction on result_ch, at a sustained rate of one byte per clock cycle while the
// output is not stalled. ASCII letters are shifted forward (mode 0) or backward (mode 1)
// by the current key shift, keeping their case; every other byte passes unchanged and
// leaves the key position alone, unless it starts a message or meets a stale position
// left by a shortened key, which both restart it. An accepted byte is written into the
// two-entry queue that parts the classifying front end from the shifting back end, and
// is shifted into the output register as it leaves; its result is valid once it sits
// in that register. The queue lets the input keep flowing for two bytes while the output
// is stalled; beyond that, text_ch.ready drops until a result is taken.
// Configuration is written through write_enable, reg_index and write_data and must only
// change while no byte is in flight.
module vigenere_stream_cipher_core #(
	parameter int KEY_MAX = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	vsc_text_if.sink                              text_ch,
	vsc_result_if.source                          result_ch,
	input  logic                                  write_enable,
	input  logic [vsc_pkg::REG_INDEX_W-1:0]       reg_index,
	input  logic [vsc_pkg::KEY_REG_W-1:0]         write_data
);

	// Configuration registers. All clear to zero except the key length, which
	// comes out of reset as one.
	logic                               mode_q;
	logic [vsc_pkg::KEY_LEN_W-1:0]      key_length_q;
	logic [vsc_pkg::KEY_REG_W-1:0]      key_shifts_q [vsc_pkg::KEY_REGS];
	logic [vsc_pkg::KEY_BITS-1:0]       key_flat;

	// Links between the front end, the queue and the back end.
	logic                               push;
	logic                               pop;
	vsc_pkg::queue_entry_t              push_entry;
	vsc_pkg::queue_entry_t              head_entry;
	vsc_pkg::queue_status_t             q_status;
	vsc_pkg::front_status_t             f_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			key_length_q <= vsc_pkg::KEY_LEN_W'(1);
			for (int i = 0; i < vsc_pkg::KEY_REGS; i++) begin
				key_shifts_q[i] <= '0;
			end
		end else if (write_enable) begin
			unique case (vsc_pkg::cfg_reg_t'(reg_index))
				vsc_pkg::REG_MODE:         mode_q          <= write_data[0];
				vsc_pkg::REG_KEY_LENGTH:   key_length_q    <= write_data[vsc_pkg::KEY_LEN_W-1:0];
				vsc_pkg::REG_KEY_SHIFTS_0: key_shifts_q[0] <= write_data;
				vsc_pkg::REG_KEY_SHIFTS_1: key_shifts_q[1] <= write_data;
				vsc_pkg::REG_KEY_SHIFTS_2: key_shifts_q[2] <= write_data;
				vsc_pkg::REG_KEY_SHIFTS_3: key_shifts_q[3] <= write_data;
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	// Key shift i sits at bits 5*i+4..5*i of this flat vector, so the twelve
	// shifts of each register line up one after the other.
	assign key_flat = {key_shifts_q[3], key_shifts_q[2], key_shifts_q[1], key_shifts_q[0]};

	// The front end classifies each accepted byte and picks its key shift.
	vsc_front #(
		.KEY_MAX (KEY_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_ch    (text_ch),
		.key_length (key_length_q),
		.key_flat   (key_flat),
		.q_full     (q_status.full),
		.push       (push),
		.push_entry (push_entry),
		.status     (f_status)
	);

	vsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.status     (q_status)
	);

	// The back end does the modulo-26 shift and owns the output register.
	vsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.head_entry (head_entry),
		.q_empty    (q_status.empty),
		.pop        (pop),
		.result_ch  (result_ch)
	);

	// The key position always stays below KEY_MAX, inside the key store.
	assert property (@(posedge clk) disable iff (!arst_n)
		f_status.key_position < vsc_pkg::KEY_LEN_W'(KEY_MAX))
	else $error("key position beyond the key store");

	// The back end never takes an entry from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
	else $error("pop from empty queue");

	// A byte that is not a letter leaves the key position alone, apart from a restart.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_entry.is_letter) |=>
		(f_status.key_position == '0) || (f_status.key_position == $past(f_status.key_position)))
	else $error("non-letter advanced the key position");

	// A result that is shifted is still a letter, upper or lower case.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_entry.is_letter) |=>
		((result_ch.result_byte >= vsc_pkg::CHAR_UP_A) && (result_ch.result_byte <= vsc_pkg::CHAR_UP_Z)) ||
		((result_ch.result_byte >= vsc_pkg::CHAR_LO_A) && (result_ch.result_byte <= vsc_pkg::CHAR_LO_Z)))
	else $error("shifted letter left the alphabet");

endmodule

FILE: hdl/vsc_queue.sv
// Two-entry queue of classified characters between the front and back ends.
// Depends on vsc_pkg for the entry and status types.
module vsc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vsc_pkg::queue_entry_t push_entry,
	input  logic                  pop,
	output vsc_pkg::queue_entry_t head_entry,
	output vsc_pkg::queue_status_t status
);

	vsc_pkg::queue_entry_t              slot_q [vsc_pkg::QUEUE_DEPTH];
	logic [vsc_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [vsc_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [vsc_pkg::QCNT_W-1:0]         count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + vsc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + vsc_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + vsc_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - vsc_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_entry   = slot_q[rd_ptr_q];
	assign status.full  = (count_q == vsc_pkg::QCNT_W'(vsc_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule

FILE: hdl/vsc_front.sv
// Front end of the cipher core: accepts text transactions, classifies letters,
// tracks the key position and looks up the key shift. Depends on vsc_pkg and vsc_stream_if.
module vsc_front #(
	parameter int KEY_MAX = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	vsc_text_if.sink                            text_ch,
	input  logic [vsc_pkg::KEY_LEN_W-1:0]       key_length,
	input  logic [vsc_pkg::KEY_BITS-1:0]        key_flat,
	input  logic                                q_full,
	output logic                                push,
	output vsc_pkg::queue_entry_t               push_entry,
	output vsc_pkg::front_status_t              status
);

	localparam int KPW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam logic [vsc_pkg::KEY_LEN_W-1:0] KEY_MAX_L = vsc_pkg::KEY_LEN_W'(KEY_MAX);

	logic [KPW-1:0]                    kpos_q;
	logic [KPW-1:0]                    pos_use;
	logic [KPW-1:0]                    kpos_d;
	logic [vsc_pkg::KEY_LEN_W-1:0]     eff_len;
	logic [vsc_pkg::KEY_LEN_W-1:0]     pos_next;
	logic [vsc_pkg::SHIFT_W-1:0]       shift_raw;
	logic [vsc_pkg::BYTE_W-1:0]        base;
	logic [vsc_pkg::BYTE_W-1:0]        diff;
	logic                              is_upper;
	logic                              is_lower;

	always_comb begin
		if (key_length == '0) begin
			eff_len = vsc_pkg::KEY_LEN_W'(1);
		end else if (key_length > KEY_MAX_L) begin
			eff_len = KEY_MAX_L;
		end else begin
			eff_len = key_length;
		end

		// A new message, or a stale position left by a shortened key, restarts at the first shift.
		if (text_ch.start_of_message || (vsc_pkg::KEY_LEN_W'(kpos_q) >= eff_len)) begin
			pos_use = '0;
		end else begin
			pos_use = kpos_q;
		end

		shift_raw = key_flat[vsc_pkg::SHIFT_W * int'(pos_use) +: vsc_pkg::SHIFT_W];

		is_upper = (text_ch.text_byte >= vsc_pkg::CHAR_UP_A) &&
		           (text_ch.text_byte <= vsc_pkg::CHAR_UP_Z);
		is_lower = (text_ch.text_byte >= vsc_pkg::CHAR_LO_A) &&
		           (text_ch.text_byte <= vsc_pkg::CHAR_LO_Z);
		base     = is_lower ? vsc_pkg::CHAR_LO_A : vsc_pkg::CHAR_UP_A;
		diff     = text_ch.text_byte - base;

		pos_next = vsc_pkg::KEY_LEN_W'(pos_use) + vsc_pkg::KEY_LEN_W'(1);
		if (is_upper || is_lower) begin
			kpos_d = (pos_next >= eff_len) ? '0 : KPW'(pos_next);
		end else begin
			kpos_d = pos_use;
		end

		push_entry.text_byte = text_ch.text_byte;
		push_entry.is_letter = is_upper || is_lower;
		push_entry.is_lower  = is_lower;
		push_entry.offset    = diff[vsc_pkg::SHIFT_W-1:0];
		push_entry.shift     = (shift_raw >= vsc_pkg::ALPHABET) ?
		                       (shift_raw - vsc_pkg::ALPHABET) : shift_raw;
	end

	assign text_ch.ready = !q_full;
	assign push          = text_ch.valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kpos_q <= '0;
		end else if (push) begin
			kpos_q <= kpos_d;
		end
	end

	assign status.key_position = vsc_pkg::KEY_LEN_W'(kpos_q);

endmodule

FILE: hdl/vsc_back.sv
// Back end of the cipher core: shifts a queued letter modulo 26, passes any other byte
// unchanged and holds the result in the output register. Depends on vsc_pkg and vsc_stream_if.
module vsc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   mode,
	input  vsc_pkg::queue_entry_t  head_entry,
	input  logic                   q_empty,
	output logic                   pop,
	vsc_result_if.source           result_ch
);

	localparam logic [vsc_pkg::SHIFT_W:0] ALPHA6 = {1'b0, vsc_pkg::ALPHABET};

	logic                              out_valid_q;
	logic [vsc_pkg::BYTE_W-1:0]        result_q;
	logic                              take;
	logic [vsc_pkg::SHIFT_W:0]         sum;
	logic [vsc_pkg::SHIFT_W:0]         wrapped;
	logic [vsc_pkg::BYTE_W-1:0]        base;
	logic [vsc_pkg::BYTE_W-1:0]        result_d;

	always_comb begin
		if (mode) begin
			sum = {1'b0, head_entry.offset} + ALPHA6 - {1'b0, head_entry.shift};
		end else begin
			sum = {1'b0, head_entry.offset} + {1'b0, head_entry.shift};
		end
		wrapped  = (sum >= ALPHA6) ? (sum - ALPHA6) : sum;
		base     = head_entry.is_lower ? vsc_pkg::CHAR_LO_A : vsc_pkg::CHAR_UP_A;
		result_d = head_entry.is_letter ?
		           (base + vsc_pkg::BYTE_W'(wrapped[vsc_pkg::SHIFT_W-1:0])) :
		           head_entry.text_byte;
	end

	assign take = !out_valid_q || result_ch.ready;
	assign pop  = take && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= result_d;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.result_byte = result_q;

endmodule
